[hw/rtl/fsp_pkg.sv]
// Shared types and constants for the fragment segment pairer.
// Used by fsp_ctrl, fsp_datapath and fragment_segment_pairer_unit.
package fsp_pkg;

    // Stream widths, padded to whole bytes
    localparam int IN_W  = 128;
    localparam int OUT_W = 104;

    // Config port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_QUAL = 2'd2;

    localparam logic [30:0] GAP_MIN_RST  = 31'd1000;
    localparam logic [3:0]  MAX_SEG_RST  = 4'd3;
    localparam logic [7:0]  MIN_QUAL_RST = 8'd20;

    // One buffered segment
    typedef struct packed {
        logic [15:0]        chrom;
        logic [30:0]        seg_start;
        logic [30:0]        seg_end;
        logic [7:0]         quality;
        logic signed [1:0]  phase;
        logic signed [1:0]  strand;
    } seg_t;

    // One contact pair
    typedef struct packed {
        logic [15:0]        chrom_a;
        logic [15:0]        chrom_b;
        logic [30:0]        pos_a;
        logic [30:0]        pos_b;
        logic signed [1:0]  phase_a;
        logic signed [1:0]  phase_b;
        logic signed [1:0]  strand_a;
        logic signed [1:0]  strand_b;
    } pair_t;

    // Ordered candidate pair, before the distance filter
    typedef struct packed {
        pair_t legs;
        logic  same_chrom;
        logic  qual_ok;
    } cand_t;

    // Controller -> datapath
    typedef struct packed {
        logic latch_in;     // capture input word
        logic walk_start;   // index to zero
        logic rd;           // read buffer at index
        logic ld_prev;      // read data becomes earlier segment
        logic ld_cand;      // build candidate from earlier and read segment
        logic idx_inc;
        logic push;         // kept candidate goes to pending slot
        logic flush;        // pending goes out marked last
        logic store;        // append captured segment to group
        logic clear_group;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic id_differs;   // open group and new id
        logic walk_ok;      // group size allows pairs
        logic idx_zero;
        logic idx_more;     // index + 1 below count
        logic in_last;
        logic keep;         // candidate survives filters
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

[hw/rtl/fragment_segment_pairer_unit.sv]
// Fragment segment pairer, top level: state machine plus datapath.
// Depends on fsp_pkg, fsp_ctrl, fsp_datapath.
// A word that closes no group goes through accept, id check and store. Closing a group
// that passes the size checks walks the buffer: start, read and load per segment, evaluate
// per later one, flush; a group too small or too large for pairs just starts and flushes.
// A pair is shown once the next kept pair or the end of the walk is found.
// Reset: aresetn synchronous, active low; clears group state, config to defaults.
module fragment_segment_pairer_unit #(
    parameter int MAX_GROUP = 8     // segment buffer depth, 2..64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Segment input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fragment_id[31:0], chrom[47:32], seg_start[78:48], seg_end[109:79],
    // quality[117:110], haplotype[119:118], orientation[121:120], zero pad
    input  logic [fsp_pkg::IN_W-1:0]        s_tdata,
    input  logic                            s_tlast,    // stream_end
    // Pair output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chrom_a[15:0], chrom_b[31:16], pos_a[62:32], pos_b[93:63],
    // phase_a[95:94], phase_b[97:96], strand_a[99:98], strand_b[101:100], zero pad
    output logic [fsp_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast,    // run_last
    // Config write: 0 min_distance, 1 max_segments, 2 min_quality
    input  logic                            cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsp_pkg::CFG_W-1:0]       cfg_wdata
);

    fsp_pkg::cmd_t cmd;
    fsp_pkg::sts_t sts;

    // Sequencer: one word in flight; it is held in IDLE only
    fsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Buffer, ordering and filter; the output register decouples m_tready
    fsp_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[hw/rtl/fsp_ctrl.sv]
// Sequencing state machine for the fragment segment pairer.
// Depends on fsp_pkg (cmd_t, sts_t).
module fsp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fsp_pkg::sts_t  sts,
    output fsp_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LD    = 3'd4;
    localparam logic [2:0] S_EV    = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;
    localparam logic [2:0] S_STORE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       final_close_reg, final_close_next;  // closing after the store

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            final_close_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            final_close_reg <= final_close_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd              = '0;
        state_next       = state_reg;
        final_close_next = final_close_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.id_differs) begin
                    final_close_next = 1'b0;
                    state_next       = S_START;
                end else begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                if (sts.in_last) begin
                    final_close_next = 1'b1;
                    state_next       = S_START;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_START: begin
                cmd.walk_start = 1'b1;
                state_next     = sts.walk_ok ? S_RD : S_FLUSH;
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_LD;
            end
            S_LD: begin
                if (sts.idx_zero) begin
                    cmd.ld_prev = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end else begin
                    cmd.ld_cand = 1'b1;
                    state_next  = S_EV;
                end
            end
            S_EV: begin
                // stall only when a kept pair must displace a pending one
                if (!(sts.keep && sts.pend_valid && !sts.out_free)) begin
                    cmd.push    = sts.keep;
                    cmd.idx_inc = 1'b1;
                    state_next  = sts.idx_more ? S_RD : S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.flush       = sts.pend_valid;
                    cmd.clear_group = 1'b1;
                    state_next      = final_close_reg ? S_IDLE : S_STORE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/fsp_datapath.sv]
// Datapath of the fragment segment pairer: config registers, segment
// buffer, group counters, leg ordering, distance filter, output register.
// Depends on fsp_pkg.
module fsp_datapath #(
    parameter int MAX_GROUP = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fsp_pkg::IN_W-1:0]        s_tdata,
    input  logic                            s_tlast,
    input  logic                            cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsp_pkg::CFG_W-1:0]       cfg_wdata,
    input  fsp_pkg::cmd_t                   cmd,
    output fsp_pkg::sts_t                   sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsp_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tlast
);

    localparam int CW   = $clog2(MAX_GROUP + 2);
    localparam int AW   = $clog2(MAX_GROUP);
    localparam int CMPW = (CW > 4) ? CW : 4;

    // Config
    logic [30:0] gap_min_reg;
    logic [3:0]  max_seg_reg;
    logic [7:0]  min_qual_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_min_reg  <= fsp_pkg::GAP_MIN_RST;
            max_seg_reg  <= fsp_pkg::MAX_SEG_RST;
            min_qual_reg <= fsp_pkg::MIN_QUAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                fsp_pkg::REG_GAP_MIN:  gap_min_reg  <= cfg_wdata;
                fsp_pkg::REG_MAX_SEG:  max_seg_reg  <= cfg_wdata[3:0];
                fsp_pkg::REG_MIN_QUAL: min_qual_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Captured input word
    logic [31:0]   in_id_reg;
    fsp_pkg::seg_t in_seg_reg;
    logic          in_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_id_reg            <= s_tdata[31:0];
            in_seg_reg.chrom     <= s_tdata[47:32];
            in_seg_reg.seg_start <= s_tdata[78:48];
            in_seg_reg.seg_end   <= s_tdata[109:79];
            in_seg_reg.quality   <= s_tdata[117:110];
            in_seg_reg.phase     <= s_tdata[119:118];
            in_seg_reg.strand    <= s_tdata[121:120];
            in_last_reg          <= s_tlast;
        end
    end

    // Group bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   gid_reg, gid_next;
    logic          open_reg, open_next;
    logic [CW-1:0] idx_reg, idx_next;

    always_comb begin
        count_next = count_reg;
        gid_next   = gid_reg;
        open_next  = open_reg;
        idx_next   = idx_reg;
        if (cmd.clear_group) begin
            count_next = '0;
            open_next  = 1'b0;
        end else if (cmd.store) begin
            open_next = 1'b1;
            if (!open_reg) gid_next = in_id_reg;
            if (count_reg <= CW'(MAX_GROUP)) count_next = count_reg + CW'(1);
        end
        if (cmd.walk_start)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            gid_reg   <= '0;
            open_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            gid_reg   <= gid_next;
            open_reg  <= open_next;
            idx_reg   <= idx_next;
        end
    end

    // Segment buffer, one write and one registered read port
    fsp_pkg::seg_t seg_mem [MAX_GROUP];
    fsp_pkg::seg_t rd_seg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store && (count_reg < CW'(MAX_GROUP)))
            seg_mem[count_reg[AW-1:0]] <= in_seg_reg;
        if (cmd.rd)
            rd_seg_reg <= seg_mem[idx_reg[AW-1:0]];
    end

    // Leg ordering: t is the earlier segment, s the later one
    fsp_pkg::seg_t  prev_reg;
    fsp_pkg::cand_t cand_reg, cand_next;
    logic           a_is_t;

    always_comb begin
        a_is_t = (prev_reg.chrom < rd_seg_reg.chrom) ||
                 ((prev_reg.chrom == rd_seg_reg.chrom) &&
                  (prev_reg.seg_end < rd_seg_reg.seg_start));
        cand_next.same_chrom = (prev_reg.chrom == rd_seg_reg.chrom);
        cand_next.qual_ok    = (prev_reg.quality >= min_qual_reg) &&
                               (rd_seg_reg.quality >= min_qual_reg);
        if (a_is_t) begin
            cand_next.legs.chrom_a  = prev_reg.chrom;
            cand_next.legs.chrom_b  = rd_seg_reg.chrom;
            cand_next.legs.pos_a    = prev_reg.seg_end;
            cand_next.legs.pos_b    = rd_seg_reg.seg_start;
            cand_next.legs.phase_a  = prev_reg.phase;
            cand_next.legs.phase_b  = rd_seg_reg.phase;
            cand_next.legs.strand_a = prev_reg.strand;
            cand_next.legs.strand_b = rd_seg_reg.strand;
        end else begin
            cand_next.legs.chrom_a  = rd_seg_reg.chrom;
            cand_next.legs.chrom_b  = prev_reg.chrom;
            cand_next.legs.pos_a    = rd_seg_reg.seg_start;
            cand_next.legs.pos_b    = prev_reg.seg_end;
            cand_next.legs.phase_a  = rd_seg_reg.phase;
            cand_next.legs.phase_b  = prev_reg.phase;
            cand_next.legs.strand_a = rd_seg_reg.strand;
            cand_next.legs.strand_b = prev_reg.strand;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_prev || cmd.ld_cand)
            prev_reg <= rd_seg_reg;
        if (cmd.ld_cand)
            cand_reg <= cand_next;
    end

    // Distance filter: strands oppose when one is negative, other is +1
    logic signed [31:0] leg_diff;
    logic               opposed;
    logic               too_close;

    always_comb begin
        leg_diff  = $signed({1'b0, cand_reg.legs.pos_b}) -
                    $signed({1'b0, cand_reg.legs.pos_a});
        opposed   = (cand_reg.legs.strand_a[1] && (cand_reg.legs.strand_b == 2'sd1)) ||
                    (cand_reg.legs.strand_b[1] && (cand_reg.legs.strand_a == 2'sd1));
        too_close = cand_reg.same_chrom && !opposed &&
                    (leg_diff < $signed({1'b0, gap_min_reg}));
    end

    // Pending slot holds the newest kept pair until its last flag is known
    fsp_pkg::pair_t pend_reg;
    logic           pend_valid_reg;
    fsp_pkg::pair_t out_reg;
    logic           out_valid_reg;
    logic           out_last_reg;
    logic           out_free;
    logic           out_load;

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (cmd.push && pend_valid_reg) || cmd.flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.push)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push)
            pend_reg <= cand_reg.legs;
        if (out_load) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    // Status
    logic [CMPW-1:0] count_cmp;
    assign count_cmp = CMPW'(count_reg);

    assign sts.id_differs = open_reg && (in_id_reg != gid_reg);
    assign sts.walk_ok    = (count_reg >= CW'(2)) && (count_reg <= CW'(MAX_GROUP)) &&
                            (count_cmp <= CMPW'(max_seg_reg));
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_more   = ({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, count_reg};
    assign sts.in_last    = in_last_reg;
    assign sts.keep       = cand_reg.qual_ok && !too_close;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00,
                       out_reg.strand_b, out_reg.strand_a,
                       out_reg.phase_b,  out_reg.phase_a,
                       out_reg.pos_b,    out_reg.pos_a,
                       out_reg.chrom_b,  out_reg.chrom_a};

endmodule

[hw/rtl/fsp_checker.sv]
// Port-level checks for the fragment segment pairer.
// Depends on fsp_pkg; bound to fragment_segment_pairer_unit.
module fsp_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [fsp_pkg::OUT_W-1:0]  m_tdata
);

    // Out of reset: idle and nothing shown
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("not idle after reset");

    // One word at a time: no accept right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // Stalled pair holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled pair changed");

    // Legs ordered by chromosome, then position
    a_leg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[15:0] < m_tdata[31:16]) ||
                      ((m_tdata[15:0] == m_tdata[31:16]) &&
                       (m_tdata[62:32] <= m_tdata[93:63]))))
        else $error("legs out of order");

endmodule

bind fragment_segment_pairer_unit fsp_checker u_fsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
